// File: rtl/core/dlsc_pkg.sv
// Shared constants and types of the dual LFSR stream cipher unit.
package dlsc_pkg;

  localparam int SHORT_LEN_DEF = 17;
  localparam int LONG_LEN_DEF  = 25;
  localparam int LEN_MAX       = 32;

  localparam int KEY_W     = 8;
  localparam int KEY_COUNT = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [KEY_W-1:0] KEY_IDX_LAST = KEY_W'(KEY_COUNT - 1);

  localparam logic [LEN_MAX-1:0] SHORT_TAPS = (LEN_MAX'(1) << 0) | (LEN_MAX'(1) << 14);
  localparam logic [LEN_MAX-1:0] LONG_TAPS  = (LEN_MAX'(1) << 0) | (LEN_MAX'(1) << 3)
                                            | (LEN_MAX'(1) << 4) | (LEN_MAX'(1) << 14);

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_DATA = 1'b1
  } kind_t;

endpackage

// File: rtl/core/dlsc_key_regs.sv
// Key byte registers and the seed words built from them.
module dlsc_key_regs #(
  parameter int SHORT_LEN = dlsc_pkg::SHORT_LEN_DEF,
  parameter int LONG_LEN  = dlsc_pkg::LONG_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [dlsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dlsc_pkg::KEY_W-1:0]         cfg_data,
  output logic [SHORT_LEN-1:0]               short_seed,
  output logic [LONG_LEN-1:0]                long_seed
);

  logic [dlsc_pkg::KEY_W-1:0] key [dlsc_pkg::KEY_COUNT];
  logic [dlsc_pkg::LEN_MAX-1:0] short_full;
  logic [dlsc_pkg::LEN_MAX-1:0] long_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dlsc_pkg::KEY_COUNT; i++) begin
        key[i] <= '0;
      end
    end else if (cfg_we && ({5'd0, cfg_index} <= dlsc_pkg::KEY_IDX_LAST)) begin
      key[cfg_index] <= cfg_data;
    end
  end

  // Bit 8 of both seeds is always set.
  assign short_full = dlsc_pkg::LEN_MAX'({key[0], 1'b1, key[1]});
  assign long_full  = dlsc_pkg::LEN_MAX'({key[2], key[3], 1'b1, key[4]});

  assign short_seed = short_full[SHORT_LEN-1:0];
  assign long_seed  = long_full[LONG_LEN-1:0];

endmodule

// File: rtl/core/dlsc_lfsr8.sv
// Eight steps of a right-shifting Fibonacci LFSR and the byte of feedback bits.
module dlsc_lfsr8 #(
  parameter int                           LEN  = dlsc_pkg::SHORT_LEN_DEF,
  parameter logic [dlsc_pkg::LEN_MAX-1:0] TAPS = dlsc_pkg::SHORT_TAPS
) (
  input  logic [LEN-1:0] state,
  output logic [LEN-1:0] state_next,
  output logic [7:0]     ks
);

  localparam logic [LEN-1:0] TAP_MASK = TAPS[LEN-1:0];

  always_comb begin
    logic [LEN-1:0] r;
    logic           fb;
    r  = state;
    ks = '0;
    for (int i = 0; i < 8; i++) begin
      fb    = ^(r & TAP_MASK);
      ks[i] = fb;
      r     = {fb, r[LEN-1:1]};
    end
    state_next = r;
  end

endmodule

// File: rtl/core/dual_lfsr_stream_cipher_unit.sv
// Top level of the dual LFSR stream cipher unit.
//
// Each word on the slave side is either a reload (tuser low), which seeds both LFSRs from the
// five key bytes and gives no output, or a data byte (tuser high), which gives one output word:
// the byte XORed with the mod 256 sum of eight feedback bits from each LFSR. One word is taken
// every cycle unless the input stalls; a data word waits in the input register, then passes
// through the eight unrolled LFSR steps into the output register that drives the master side.
// The input stalls only while a data word waits in the input register behind an output word
// that is held by the master side. The same operation scrambles and descrambles. The user must
// write key bytes through the configuration port only while no word is in flight; the block
// itself does not enforce this. A reload uses the key bytes present when it reaches the LFSRs.
module dual_lfsr_stream_cipher_unit #(
  parameter int SHORT_LEN = dlsc_pkg::SHORT_LEN_DEF,
  parameter int LONG_LEN  = dlsc_pkg::LONG_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] data_in
  input  logic [0:0]                     s_tuser,   // [0] kind
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [7:0] data_out
  input  logic                           cfg_we,
  input  logic [dlsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dlsc_pkg::KEY_W-1:0]     cfg_data
);

  logic                  in_valid;
  dlsc_pkg::kind_t       in_kind;
  logic [7:0]            in_data;
  logic                  out_valid;
  logic [7:0]            out_data;
  logic [SHORT_LEN-1:0]  short_reg;
  logic [LONG_LEN-1:0]   long_reg;
  logic [SHORT_LEN-1:0]  short_reg_next;
  logic [LONG_LEN-1:0]   long_reg_next;
  logic [SHORT_LEN-1:0]  short_seed;
  logic [LONG_LEN-1:0]   long_seed;
  logic [7:0]            short_ks;
  logic [7:0]            long_ks;
  logic                  process;

  dlsc_key_regs #(
    .SHORT_LEN(SHORT_LEN),
    .LONG_LEN (LONG_LEN)
  ) u_keys (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .short_seed(short_seed),
    .long_seed (long_seed)
  );

  dlsc_lfsr8 #(
    .LEN (SHORT_LEN),
    .TAPS(dlsc_pkg::SHORT_TAPS)
  ) u_short (
    .state     (short_reg),
    .state_next(short_reg_next),
    .ks        (short_ks)
  );

  dlsc_lfsr8 #(
    .LEN (LONG_LEN),
    .TAPS(dlsc_pkg::LONG_TAPS)
  ) u_long (
    .state     (long_reg),
    .state_next(long_reg_next),
    .ks        (long_ks)
  );

  // A reload never needs the output register, so it moves on at once.
  assign process  = in_valid && ((in_kind == dlsc_pkg::KIND_LOAD) || !out_valid || m_tready);
  assign s_tready = !in_valid || process;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      short_reg <= '0;
      long_reg  <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (process && (in_kind == dlsc_pkg::KIND_DATA)) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (process) begin
        if (in_kind == dlsc_pkg::KIND_LOAD) begin
          short_reg <= short_seed;
          long_reg  <= long_seed;
        end else begin
          short_reg <= short_reg_next;
          long_reg  <= long_reg_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_kind <= dlsc_pkg::kind_t'(s_tuser[0]);
      in_data <= s_tdata;
    end
    if (process && (in_kind == dlsc_pkg::KIND_DATA)) begin
      out_data <= in_data ^ (short_ks + long_ks);
    end
  end

  a_reload_seeds: assert property (@(posedge clk) disable iff (rst)
    (process && (in_kind == dlsc_pkg::KIND_LOAD)) |=>
      (short_reg == $past(short_seed)) && (long_reg == $past(long_seed)))
    else $error("LFSRs not seeded by a reload");

  a_data_gives_word: assert property (@(posedge clk) disable iff (rst)
    (process && (in_kind == dlsc_pkg::KIND_DATA)) |=> out_valid)
    else $error("Data word processed without an output word");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready && (in_kind == dlsc_pkg::KIND_DATA)))
    else $error("Input stalled without a blocked output");

  a_lfsr_hold: assert property (@(posedge clk) disable iff (rst)
    !process |=> ($stable(short_reg) && $stable(long_reg)))
    else $error("LFSR state changed without a processed word");

endmodule
